// ----- design/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes for the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_GT       = 4'd8,
    OP_LT       = 4'd9,
    OP_GE       = 4'd10,
    OP_LE       = 4'd11,
    OP_EQ       = 4'd12,
    OP_NE       = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  localparam int unsigned NumerW = 62;

  typedef struct packed {
    op_e                 kind;
    logic signed [31:0]  result;
    logic                cmp;
    status_e             status;
    logic                neg;
    logic                run_div;
    logic [63:0]         q;
    logic [NumerW-1:0]   n;
    logic [31:0]         rem;
    logic [31:0]         d;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    status_e            status;
  } res_t;

endpackage

// ----- design/fpa_if.sv -----
// ----------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;
  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

// ----- design/fpa_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_cell
// One pipeline cell: registers the item and, for a divide, retires one quotient bit.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpa_pkg::cell_t data_i,
  output logic           valid_o,
  output fpa_pkg::cell_t data_o
);
  import fpa_pkg::*;

  logic        valid_q;
  cell_t       data_q, data_d;
  logic [32:0] rem_sh;
  logic        ge;

  always_comb begin
    data_d = data_i;
    rem_sh = {data_i.rem, data_i.n[NumerW-1]};
    ge     = rem_sh >= {1'b0, data_i.d};
    if (data_i.run_div) begin
      data_d.rem = ge ? 32'(rem_sh - {1'b0, data_i.d}) : rem_sh[31:0];
      data_d.q   = {data_i.q[62:0], ge};
      data_d.n   = {data_i.n[NumerW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ----- design/fpa_finish.sv -----
// ----------------------------------------------------------------------------
// fpa_finish
// Rounding, sign restore and saturation for multiply and divide.
// ----------------------------------------------------------------------------
module fpa_finish #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::cell_t data_i,
  output fpa_pkg::res_t  res_o
);
  import fpa_pkg::*;

  localparam logic [63:0] Half = 64'd1 << (FRAC_BITS - 1);

  logic        is_mul, is_div;
  logic        round_up;
  logic [63:0] sum, mag;

  always_comb begin
    is_mul   = data_i.kind == OP_MUL;
    is_div   = data_i.kind == OP_DIV && data_i.run_div;
    round_up = {data_i.rem, 1'b0} >= {1'b0, data_i.d};
    sum      = data_i.q + (is_mul ? Half : {63'd0, round_up});
    mag      = is_mul ? (sum >> FRAC_BITS) : sum;

    res_o.result_value = data_i.result;
    res_o.compare_true = data_i.cmp;
    res_o.status       = data_i.status;
    if (is_mul || is_div) begin
      if (data_i.neg) begin
        if (mag > 64'h8000_0000) begin
          res_o.result_value = 32'sh8000_0000;
          res_o.status       = ST_SAT;
        end else begin
          res_o.result_value = 32'(64'd0 - mag);
        end
      end else if (mag > 64'h7FFF_FFFF) begin
        res_o.result_value = 32'sh7FFF_FFFF;
        res_o.status       = ST_SAT;
      end else begin
        res_o.result_value = mag[31:0];
      end
    end
  end
endmodule

// ----- design/fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed fixed-point ALU with saturation, rounded multiply and divide.
//
//   channel | dir | payload                                 | transfer
//   in_i    | in  | kind, operand_a, operand_b              | valid & ready
//   out_o   | out | result_value, compare_true, status      | valid & ready
//
// One item per cycle sustained while the output is not stalled.
// The divider chain, one cell per quotient bit (32 + FRAC_BITS cells),
// sets the latency; every operation rides the same chain.
// A stalled output holds the whole chain; in_i.ready drops with it.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);
  import fpa_pkg::*;

  localparam int unsigned NumCells = 32 + FRAC_BITS;

  cell_t st [0:NumCells];
  logic  sv [0:NumCells];
  cell_t head;
  logic  advance;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;

  logic signed [31:0] a, b;
  logic [31:0]        mag_a, mag_b;
  logic signed [32:0] rhs, sum33;
  logic signed [63:0] fi;
  op_e                kind;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  always_comb begin
    kind  = op_e'(in_i.kind);
    a     = in_i.operand_a;
    b     = in_i.operand_b;
    mag_a = a[31] ? 32'(-a) : a;
    mag_b = b[31] ? 32'(-b) : b;
    case (kind)
      OP_SUB:  rhs = -{b[31], b};
      OP_INC:  rhs = 33'sd1;
      OP_DEC:  rhs = -33'sd1;
      default: rhs = {b[31], b};
    endcase
    sum33 = {a[31], a} + rhs;
    fi    = {{32{a[31]}}, a} <<< FRAC_BITS;

    head         = '0;
    head.kind    = kind;
    head.neg     = a[31] ^ b[31];
    head.status  = ST_OK;
    case (kind)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum33[32] != sum33[31]) begin
          head.result = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          head.status = ST_SAT;
        end else begin
          head.result = sum33[31:0];
        end
      end
      OP_MUL:  head.q = 64'(mag_a) * 64'(mag_b);
      OP_DIV: begin
        if (b == 32'sd0) begin
          head.status = ST_DIV0;
        end else begin
          head.run_div = 1'b1;
          head.n       = {mag_a, 30'd0};
          head.d       = mag_b;
        end
      end
      OP_MIN:  head.result = (a < b) ? a : b;
      OP_MAX:  head.result = (a > b) ? a : b;
      OP_GT:   head.cmp = a > b;
      OP_LT:   head.cmp = a < b;
      OP_GE:   head.cmp = a >= b;
      OP_LE:   head.cmp = a <= b;
      OP_EQ:   head.cmp = a == b;
      OP_NE:   head.cmp = a != b;
      OP_TO_INT: head.result = a >>> FRAC_BITS;
      OP_FROM_INT: begin
        if (fi > 64'sh7FFF_FFFF) begin
          head.result = 32'sh7FFF_FFFF;
          head.status = ST_SAT;
        end else if (fi < -64'sh8000_0000) begin
          head.result = 32'sh8000_0000;
          head.status = ST_SAT;
        end else begin
          head.result = fi[31:0];
        end
      end
      default: head.result = 32'sd0;
    endcase
  end

  assign st[0] = head;
  assign sv[0] = in_i.valid;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (sv[i]),
      .data_i  (st[i]),
      .valid_o (sv[i+1]),
      .data_o  (st[i+1])
    );
  end

  fpa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .data_i (st[NumCells]),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= sv[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_q.result_value;
  assign out_o.compare_true = out_q.compare_true;
  assign out_o.status       = out_q.status;
endmodule

// ----- design/fpa_checker.sv -----
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_value_i,
  input logic        compare_true_i,
  input logic [1:0]  status_i
);
  import fpa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_value_i)
      && $stable(status_i) && $stable(compare_true_i))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

  a_div0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_DIV0 |-> result_value_i == 32'd0 && !compare_true_i)
    else $error("division by zero result not cleared");

  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && compare_true_i |-> result_value_i == 32'd0 && status_i == ST_OK)
    else $error("comparison result carries value or status");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i != 2'd3)
    else $error("undefined status code");
endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .compare_true_i (out_o.compare_true),
  .status_i       (out_o.status)
);

// ----- tb/sv/fixed_point_alu_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_top_tb
// Drives operation requests into the fixed-point ALU, predicts each result
// on exact integers and checks the outputs in order, under random idling.
// ----------------------------------------------------------------------------
module fixed_point_alu_top_tb;
  import fpa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency = 34 + FracBits;
  localparam longint MaxVal = 64'sd2147483647;
  localparam longint MinVal = -64'sd2147483648;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    op_e                kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpa_in_if  in_if();
  fpa_out_if out_if();

  fixed_point_alu_top #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  req_t   pending_q[$];
  res_t   expected_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_send = 1'b0;
  int     stall_cycles = 0;
  longint cycles = 0;

  function automatic longint saturate(longint v, ref status_e st);
    if (v > MaxVal) begin
      st = ST_SAT;
      return MaxVal;
    end
    if (v < MinVal) begin
      st = ST_SAT;
      return MinVal;
    end
    return v;
  endfunction

  function automatic res_t alu_result(req_t rq);
    res_t        rs;
    longint      a, b, r;
    logic [63:0] ma, mb, m, q, rem;
    bit          neg;
    status_e     st;
    a = rq.operand_a;
    b = rq.operand_b;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    r = 0;
    st = ST_OK;
    rs.compare_true = 1'b0;
    case (rq.kind)
      OP_ADD: r = saturate(a + b, st);
      OP_SUB: r = saturate(a - b, st);
      OP_MUL: begin
        m = (ma * mb + (64'd1 << (FracBits - 1))) >> FracBits;
        r = saturate(neg ? -longint'(m) : longint'(m), st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          m = ma << FracBits;
          q = m / mb;
          rem = m % mb;
          if (rem >= mb - rem) q++;
          r = saturate(neg ? -longint'(q) : longint'(q), st);
        end
      end
      OP_INC: r = saturate(a + 1, st);
      OP_DEC: r = saturate(a - 1, st);
      OP_MIN: r = (a < b) ? a : b;
      OP_MAX: r = (a > b) ? a : b;
      OP_GT:  rs.compare_true = a > b;
      OP_LT:  rs.compare_true = a < b;
      OP_GE:  rs.compare_true = a >= b;
      OP_LE:  rs.compare_true = a <= b;
      OP_EQ:  rs.compare_true = a == b;
      OP_NE:  rs.compare_true = a != b;
      OP_TO_INT: r = a >>> FracBits;
      default: begin
        m = ma << FracBits;
        r = saturate((a < 0) ? -longint'(m) : longint'(m), st);
      end
    endcase
    rs.result_value = r[31:0];
    rs.status = st;
    return rs;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 4095)) - 2048;
      2: return 32'sh7fffffff - $urandom_range(0, 300);
      3: return 32'sh80000000 + $urandom_range(0, 300);
      4: return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return $urandom_range(0, 3) == 0 ? 32'sd0 : $signed($urandom()) >>> 16;
    endcase
  endfunction

  task automatic push_op(op_e k, logic signed [31:0] a, logic signed [31:0] b);
    req_t rq;
    rq.kind = k;
    rq.operand_a = a;
    rq.operand_b = b;
    pending_q.push_back(rq);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_if.valid || expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.kind <= '0;
      in_if.operand_a <= '0;
      in_if.operand_b <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid && in_if.ready)
        expected_q.push_back(alu_result(req_t'({in_if.kind, in_if.operand_a, in_if.operand_b})));
      if (pending_q.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        req_t rq;
        rq = pending_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= rq.kind;
        in_if.operand_a <= rq.operand_a;
        in_if.operand_b <= rq.operand_b;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer value=%0d", out_if.result_value);
          errors++;
        end else begin
          res_t ex;
          ex = expected_q.pop_front();
          if (out_if.result_value !== ex.result_value) begin
            $error("result_value: expected %0d, actual %0d", ex.result_value,
                   out_if.result_value);
            errors++;
          end
          if (out_if.compare_true !== ex.compare_true) begin
            $error("compare_true: expected %0d, actual %0d", ex.compare_true,
                   out_if.compare_true);
            errors++;
          end
          if (out_if.status !== ex.status) begin
            $error("status: expected %0d, actual %0d", ex.status, out_if.status);
            errors++;
          end
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** fixed_point_alu_top: FAILED **");
      $finish;
    end
  end

  initial begin
    op_e k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners
    push_op(OP_ADD, 32'sh7fffffff, 32'sd1);
    push_op(OP_SUB, 32'sh80000000, 32'sd1);
    push_op(OP_MUL, 32'sh80000000, 32'sh80000000);
    push_op(OP_MUL, 32'sd384, -32'sd1);
    push_op(OP_MUL, -32'sd128, 32'sd1);
    push_op(OP_DIV, 32'sd100, 32'sd0);
    push_op(OP_DIV, 32'sh80000000, -32'sd1);
    push_op(OP_DIV, 32'sd1, 32'sd512);
    push_op(OP_DIV, -32'sd7, 32'sd3);
    push_op(OP_INC, 32'sh7fffffff, 32'sd0);
    push_op(OP_DEC, 32'sh80000000, 32'sd0);
    push_op(OP_MIN, 32'sh80000000, 32'sh7fffffff);
    push_op(OP_MAX, 32'sh80000000, 32'sh7fffffff);
    push_op(OP_GT, 32'sd5, 32'sd5);
    push_op(OP_LT, -32'sd1, 32'sd0);
    push_op(OP_GE, 32'sd5, 32'sd5);
    push_op(OP_LE, 32'sd6, 32'sd5);
    push_op(OP_EQ, -32'sd9, -32'sd9);
    push_op(OP_NE, 32'sd1, 32'sd2);
    push_op(OP_TO_INT, -32'sd1, 32'sd0);
    push_op(OP_TO_INT, 32'sh80000000, 32'sd0);
    push_op(OP_FROM_INT, 32'sh00800000, 32'sd0);
    push_op(OP_FROM_INT, 32'sh80000000, 32'sd0);
    push_op(OP_FROM_INT, -32'sd3, 32'sd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 38 : 0;
      for (int i = 0; i < 300; i++) begin
        k = op_e'($urandom_range(0, 15));
        push_op(k, rand_operand(), rand_operand());
      end
      if (phase == 1) begin
        while (pending_q.size() > 200) @(posedge clk_i);
        stall_cycles <= 300;
        while (pending_q.size() > 100) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_if.valid || expected_q.size() != 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end

    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** fixed_point_alu_top: PASSED **");
    end else begin
      $display("** fixed_point_alu_top: FAILED **");
    end
    $finish;
  end

endmodule
